// ===== rtl/core/lru_page_table_defines.svh =====
// Assertion macros used by the page table top level.
`ifndef LRU_PAGE_TABLE_DEFINES_SVH
`define LRU_PAGE_TABLE_DEFINES_SVH

`ifndef SYNTH
// Plain property, checked on every clock edge outside reset.
`define LPT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Same-cycle implication, checked on every clock edge outside reset.
`define LPT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define LPT_ASSERT(lbl, prop, msg)
`define LPT_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/core/lpt_pkg.sv =====
// Shared constants and link types of the LRU page table.
package lpt_pkg;

    localparam int DEF_ENTRIES   = 4;
    localparam int DEF_PAGE_BITS = 20;
    // Widest slot index or rank the table is built for (up to 64 entries).
    localparam int MAX_IDX_BITS  = 6;
    localparam int LIM_BITS      = MAX_IDX_BITS + 1;

    // Priority chain handed from each cell to the next.
    typedef struct packed {
        logic                    found;
        logic [MAX_IDX_BITS-1:0] hit_slot;
        logic [MAX_IDX_BITS-1:0] hit_rank;
        logic                    free_seen;
        logic [MAX_IDX_BITS-1:0] free_slot;
        logic                    victim_seen;
        logic [MAX_IDX_BITS-1:0] victim_slot;
    } lpt_link_t;

    // Update broadcast to every cell when a reference is taken.
    typedef struct packed {
        logic                    fire;
        logic                    write_tag;
        logic [MAX_IDX_BITS-1:0] slot;
        logic [LIM_BITS-1:0]     age_limit;
    } lpt_upd_t;

endpackage

// ===== rtl/core/lpt_cell.sv =====
// One table entry: tag, valid bit and recency rank, with its link in the priority chain.
module lpt_cell #(
    parameter int ENTRIES   = lpt_pkg::DEF_ENTRIES,
    parameter int PAGE_BITS = lpt_pkg::DEF_PAGE_BITS,
    parameter int IDX       = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [PAGE_BITS-1:0]  page,
    input  lpt_pkg::lpt_link_t    link_in,
    output lpt_pkg::lpt_link_t    link_out,
    input  logic [PAGE_BITS-1:0]  tag_in,
    output logic [PAGE_BITS-1:0]  tag_out,
    input  lpt_pkg::lpt_upd_t     upd
);
    import lpt_pkg::*;

    localparam int RANK_BITS = $clog2(ENTRIES);

    logic [PAGE_BITS-1:0] tag_reg;
    logic                 valid_reg;
    logic [RANK_BITS-1:0] rank_reg;

    logic match;
    logic is_victim;
    logic sel;
    logic age;

    assign match     = valid_reg && (tag_reg == page);
    assign is_victim = valid_reg && (rank_reg == RANK_BITS'(ENTRIES - 1));
    assign sel       = (upd.slot == MAX_IDX_BITS'(IDX));
    assign age       = valid_reg && (LIM_BITS'(rank_reg) < upd.age_limit);

    // Lowest-indexed cell wins each search, so a cell only claims what is still open.
    always_comb
    begin
        link_out = link_in;
        tag_out  = tag_in;
        if (match && !link_in.found)
        begin
            link_out.found    = 1'b1;
            link_out.hit_slot = MAX_IDX_BITS'(IDX);
            link_out.hit_rank = MAX_IDX_BITS'(rank_reg);
        end
        if (!valid_reg && !link_in.free_seen)
        begin
            link_out.free_seen = 1'b1;
            link_out.free_slot = MAX_IDX_BITS'(IDX);
        end
        if (is_victim && !link_in.victim_seen)
        begin
            link_out.victim_seen = 1'b1;
            link_out.victim_slot = MAX_IDX_BITS'(IDX);
            tag_out              = tag_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end
        else if (upd.fire)
        begin
            if (sel)
            begin
                valid_reg <= 1'b1;
                rank_reg  <= '0;
            end
            else if (age)
            begin
                rank_reg <= rank_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd.fire && upd.write_tag && sel)
        begin
            tag_reg <= page;
        end
    end

endmodule

// ===== rtl/core/lru_page_table.sv =====
// Top level of the fully associative page table with true LRU replacement.
//
//  Channel | Handshake           | Payload
//  --------+---------------------+-------------------------------------------
//  input   | in_valid, in_ready  | page_number
//  output  | out_valid, out_ready| hit, slot, evicted, evicted_page
//
// Each reference is resolved and the recency ranks updated in the cycle it is
// transferred; its result appears in the output register on the next cycle.
// A new reference may follow every cycle while no result waits on out_ready; the
// limit is the combinational priority chain that ripples through all ENTRIES cells.
// Reset empties the table; tags are not cleared and need no clearing pass.
// While a result waits on out_ready, in_ready is low and the table holds.
`include "lru_page_table_defines.svh"

module lru_page_table #(
    parameter int ENTRIES   = lpt_pkg::DEF_ENTRIES,
    parameter int PAGE_BITS = lpt_pkg::DEF_PAGE_BITS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [PAGE_BITS-1:0]       page_number,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       hit,
    output logic [$clog2(ENTRIES)-1:0] slot,
    output logic                       evicted,
    output logic [PAGE_BITS-1:0]       evicted_page
);
    import lpt_pkg::*;

    localparam int SLOT_BITS = $clog2(ENTRIES);

    lpt_link_t            link [0:ENTRIES];
    logic [PAGE_BITS-1:0] tag_chain [0:ENTRIES];
    lpt_upd_t             upd;
    lpt_link_t            res;
    logic                 in_fire;
    logic                 miss_full;
    logic [MAX_IDX_BITS-1:0] sel_slot;

    logic                 out_valid_reg;
    logic                 hit_reg;
    logic [SLOT_BITS-1:0] slot_reg;
    logic                 evicted_reg;
    logic [PAGE_BITS-1:0] evicted_page_reg;

    assign link[0]      = '0;
    assign tag_chain[0] = '0;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        lpt_cell #(
            .ENTRIES   (ENTRIES),
            .PAGE_BITS (PAGE_BITS),
            .IDX       (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .page     (page_number),
            .link_in  (link[i]),
            .link_out (link[i+1]),
            .tag_in   (tag_chain[i]),
            .tag_out  (tag_chain[i+1]),
            .upd      (upd)
        );
    end

    assign res       = link[ENTRIES];
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign miss_full = !res.found && !res.free_seen;

    always_comb
    begin
        if (res.found)
        begin
            sel_slot = res.hit_slot;
        end
        else if (res.free_seen)
        begin
            sel_slot = res.free_slot;
        end
        else
        begin
            sel_slot = res.victim_slot;
        end
    end

    // A hit ages only the entries younger than it; a fill ages all, an eviction all but the victim.
    always_comb
    begin
        upd.fire      = in_fire;
        upd.write_tag = !res.found;
        upd.slot      = sel_slot;
        if (res.found)
        begin
            upd.age_limit = {1'b0, res.hit_rank};
        end
        else if (res.free_seen)
        begin
            upd.age_limit = LIM_BITS'(ENTRIES);
        end
        else
        begin
            upd.age_limit = LIM_BITS'(ENTRIES - 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            hit_reg          <= res.found;
            slot_reg         <= SLOT_BITS'(sel_slot);
            evicted_reg      <= miss_full;
            evicted_page_reg <= miss_full ? tag_chain[ENTRIES] : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign hit          = hit_reg;
    assign slot         = slot_reg;
    assign evicted      = evicted_reg;
    assign evicted_page = evicted_page_reg;

    `LPT_ASSERT_IMP(a_full_has_victim, in_fire && miss_full, res.victim_seen, "no oldest entry")
    `LPT_ASSERT_IMP(a_hit_not_evict, out_valid_reg, !(hit_reg && evicted_reg), "hit with eviction")
    `LPT_ASSERT_IMP(a_page_zero, out_valid_reg && !evicted_reg, evicted_page_reg == '0, "page set")
    `LPT_ASSERT_IMP(a_hold_stalled, out_valid_reg && !out_ready, !in_ready, "taken while stalled")

endmodule
